@@ rtl/kmeans_cluster_engine_core_assert.svh @@
// assertion macros used by the rtl controller (kce_ctrl)
`ifndef KMEANS_CLUSTER_ENGINE_CORE_ASSERT_SVH
`define KMEANS_CLUSTER_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define KCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kce assertion failed");
`define KCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kce assertion failed");
`else
`define KCE_ASSERT_IMP(lbl, ante, cons)
`define KCE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/kce_pkg.sv @@
`default_nettype none
package kce_pkg;

  localparam logic [1:0] CFG_NUM_CLUSTERS   = 2'd0;
  localparam logic [1:0] CFG_NUM_DIMS       = 2'd1;
  localparam logic [1:0] CFG_MAX_ITERATIONS = 2'd2;

  localparam logic [4:0] RST_NUM_CLUSTERS   = 5'd2;
  localparam logic [5:0] RST_NUM_DIMS       = 6'd32;
  localparam logic [7:0] RST_MAX_ITERATIONS = 8'd10;

  typedef enum logic [4:0] {
    S_LOAD,
    S_COUNT,
    S_INIT_RD,
    S_INIT_WR,
    S_ITER,
    S_AS_RD,
    S_AS_SQ,
    S_AS_ACC,
    S_AS_WR,
    S_UP_CHK,
    S_UP_RD,
    S_UP_ACC,
    S_UP_DIV,
    S_UP_WAIT,
    S_UP_WR,
    S_EMIT_RD,
    S_EMIT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_COUNT,
    OP_INIT_START,
    OP_INIT_RD,
    OP_INIT_WR,
    OP_ITER,
    OP_AS_RD,
    OP_AS_SQ,
    OP_AS_ACC,
    OP_AS_WR,
    OP_UP_CHK,
    OP_UP_RD,
    OP_UP_ACC,
    OP_DIV_START,
    OP_UP_WR,
    OP_EMIT_START,
    OP_EMIT_RD,
    OP_EMIT_NEXT
  } op_e;

  typedef struct packed {
    logic count_done;
    logic n_zero;
    logic last_j;
    logic last_c;
    logic last_p;
    logic iter_done;
    logic cnt_zero;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/kce_div.sv @@
`default_nettype none
module kce_div #(
  parameter int DVW = 23,
  parameter int DSW = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic signed [DVW-1:0] dividend_i,
  input  wire logic        [DSW-1:0] divisor_i,
  output logic                       done_o,
  output logic signed      [DVW-1:0] quotient_o
);

  localparam int CNTW = $clog2(DVW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            neg_q;
  logic [DVW-1:0]  q_q;
  logic [DSW-1:0]  rem_q;
  logic [DSW-1:0]  den_q;
  logic [DSW:0]    trial;
  logic [DSW:0]    rem_d;
  logic            ge;
  logic [DVW-1:0]  mag;

  assign trial = {rem_q, q_q[DVW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? (trial - {1'b0, den_q}) : trial;
  assign mag   = dividend_i[DVW-1] ? (-dividend_i) : dividend_i;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(DVW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= mag;
      rem_q <= '0;
      den_q <= divisor_i;
      neg_q <= dividend_i[DVW-1];
    end else if (busy_q) begin
      q_q   <= {q_q[DVW-2:0], ge};
      rem_q <= rem_d[DSW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (-q_q) : q_q;

endmodule
`default_nettype wire

@@ rtl/kce_datapath.sv @@
`default_nettype none
module kce_datapath #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 32,
  parameter int COORD_WIDTH  = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [7:0]             cfg_data_i,
  input  wire kce_pkg::op_e           op_i,
  input  wire logic [COORD_WIDTH-1:0] coordinate_i,
  input  wire logic                   last_of_set_i,
  output kce_pkg::sts_t               sts_o,
  output logic [5:0]                  point_index_o,
  output logic [3:0]                  cluster_label_o,
  output logic                        assigned_o,
  output logic                        last_o
);

  localparam int DEPTH  = MAX_POINTS * MAX_DIMS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DW     = $clog2(MAX_DIMS + 1);
  localparam int KW     = $clog2(MAX_CLUSTERS + 1);
  localparam int LW     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int PW     = $clog2(MAX_POINTS + 1);
  localparam int PIW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CDEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int SQW    = 2 * (COORD_WIDTH + 1);
  localparam int DSTW   = SQW + DW;
  localparam int SW     = COORD_WIDTH + PW + 1;

  // configuration
  logic [4:0] num_clusters_q;
  logic [5:0] num_dims_q;
  logic [7:0] max_iterations_q;

  // control counters
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   rem_q;
  logic [PW-1:0]   n_q;
  logic [DW-1:0]   d_q;
  logic [KW-1:0]   k_q;
  logic [7:0]      iters_q;
  logic [7:0]      it_q;
  logic [PW-1:0]   p_q;
  logic [KW-1:0]   c_q;
  logic [DW-1:0]   j_q;
  logic [AW-1:0]   paddr_q;
  logic [AW-1:0]   base_q;
  logic [LW-1:0]   bestc_q;
  logic [PW-1:0]   counts_q [MAX_CLUSTERS];

  // payload
  logic [DSTW-1:0] dist_q;
  logic [DSTW-1:0] best_q;
  logic [SQW-1:0]  sq_q;
  logic signed [SW-1:0] sum_q;
  logic [COORD_WIDTH-1:0] pdata_q;
  logic [COORD_WIDTH-1:0] cdata_q;
  logic [LW-1:0]   ldata_q;

  // stores
  logic [COORD_WIDTH-1:0] pmem [DEPTH];
  logic [COORD_WIDTH-1:0] cmem [CDEPTH];
  logic [LW-1:0]          lmem [MAX_POINTS];

  logic [CW-1:0]   cnt_next;
  logic [DW-1:0]   d_clamp;
  logic [KW-1:0]   k_clamp;
  logic [CAW-1:0]  caddr;
  logic [AW-1:0]   d_addr;
  logic [DSTW-1:0] dist_d;
  logic signed [COORD_WIDTH:0] diff;
  logic signed [SQW-1:0]       prod;
  logic signed [SW-1:0]        pdata_ext;
  logic            div_done;
  logic signed [SW-1:0] quot;
  logic [PW+5:0]   pi_ext;
  logic [LW+3:0]   lb_ext;
  logic            last_j, last_c, last_p;

  assign cnt_next = (cnt_q < CW'(DEPTH)) ? (cnt_q + CW'(1)) : cnt_q;
  assign caddr    = CAW'(c_q * MAX_DIMS + j_q);
  assign d_addr   = AW'(d_q);
  assign dist_d   = dist_q + DSTW'(sq_q);
  assign diff     = {pdata_q[COORD_WIDTH-1], pdata_q} - {cdata_q[COORD_WIDTH-1], cdata_q};
  assign prod     = diff * diff;
  assign pdata_ext = {{(SW - COORD_WIDTH){pdata_q[COORD_WIDTH-1]}}, pdata_q};

  assign last_j = (j_q + DW'(1)) == d_q;
  assign last_c = (c_q + KW'(1)) == k_q;
  assign last_p = (p_q + PW'(1)) == n_q;

  always_comb begin
    if (num_dims_q == '0) begin
      d_clamp = DW'(1);
    end else if (int'(num_dims_q) > MAX_DIMS) begin
      d_clamp = DW'(MAX_DIMS);
    end else begin
      d_clamp = DW'(num_dims_q);
    end
    if (num_clusters_q == '0) begin
      k_clamp = KW'(1);
    end else if (int'(num_clusters_q) > MAX_CLUSTERS) begin
      k_clamp = KW'(MAX_CLUSTERS);
    end else begin
      k_clamp = KW'(num_clusters_q);
    end
  end

  always_comb begin
    sts_o.count_done = !((rem_q >= CW'(d_q)) && (n_q < PW'(MAX_POINTS)));
    sts_o.n_zero     = n_q == '0;
    sts_o.last_j     = last_j;
    sts_o.last_c     = last_c;
    sts_o.last_p     = last_p;
    sts_o.iter_done  = it_q == iters_q;
    sts_o.cnt_zero   = counts_q[c_q[LW-1:0]] == '0;
    sts_o.div_done   = div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_clusters_q   <= kce_pkg::RST_NUM_CLUSTERS;
      num_dims_q       <= kce_pkg::RST_NUM_DIMS;
      max_iterations_q <= kce_pkg::RST_MAX_ITERATIONS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kce_pkg::CFG_NUM_CLUSTERS:   num_clusters_q   <= cfg_data_i[4:0];
        kce_pkg::CFG_NUM_DIMS:       num_dims_q       <= cfg_data_i[5:0];
        kce_pkg::CFG_MAX_ITERATIONS: max_iterations_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      rem_q   <= '0;
      n_q     <= '0;
      d_q     <= '0;
      k_q     <= '0;
      iters_q <= '0;
      it_q    <= '0;
      p_q     <= '0;
      c_q     <= '0;
      j_q     <= '0;
      paddr_q <= '0;
      base_q  <= '0;
      bestc_q <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) counts_q[i] <= '0;
    end else begin
      case (op_i)
        kce_pkg::OP_LOAD: begin
          if (last_of_set_i) begin
            cnt_q   <= '0;
            rem_q   <= cnt_next;
            n_q     <= '0;
            d_q     <= d_clamp;
            k_q     <= k_clamp;
            iters_q <= max_iterations_q;
          end else begin
            cnt_q <= cnt_next;
          end
        end
        kce_pkg::OP_COUNT: begin
          rem_q <= rem_q - CW'(d_q);
          n_q   <= n_q + PW'(1);
        end
        kce_pkg::OP_INIT_START: begin
          c_q <= '0; j_q <= '0; p_q <= '0; base_q <= '0; paddr_q <= '0; it_q <= '0;
        end
        kce_pkg::OP_INIT_WR: begin
          if (!last_j) begin
            j_q     <= j_q + DW'(1);
            paddr_q <= paddr_q + AW'(1);
          end else begin
            j_q <= '0;
            c_q <= c_q + KW'(1);
            if (last_p) begin
              p_q <= '0; base_q <= '0; paddr_q <= '0;
            end else begin
              p_q     <= p_q + PW'(1);
              base_q  <= base_q + d_addr;
              paddr_q <= base_q + d_addr;
            end
          end
        end
        kce_pkg::OP_ITER: begin
          c_q <= '0; j_q <= '0; p_q <= '0; base_q <= '0; paddr_q <= '0;
          for (int i = 0; i < MAX_CLUSTERS; i++) counts_q[i] <= '0;
        end
        kce_pkg::OP_AS_ACC: begin
          if (!last_j) begin
            j_q     <= j_q + DW'(1);
            paddr_q <= paddr_q + AW'(1);
          end else begin
            if ((c_q == '0) || (dist_d < best_q)) bestc_q <= c_q[LW-1:0];
            j_q     <= '0;
            paddr_q <= base_q;
            c_q     <= c_q + KW'(1);
          end
        end
        kce_pkg::OP_AS_WR: begin
          counts_q[bestc_q] <= counts_q[bestc_q] + PW'(1);
          c_q <= '0;
          if (last_p) begin
            p_q <= '0; base_q <= '0; paddr_q <= '0;
          end else begin
            p_q     <= p_q + PW'(1);
            base_q  <= base_q + d_addr;
            paddr_q <= base_q + d_addr;
          end
        end
        kce_pkg::OP_UP_CHK: begin
          p_q <= '0; j_q <= '0; paddr_q <= '0;
          if (counts_q[c_q[LW-1:0]] == '0) begin
            c_q <= c_q + KW'(1);
            if (last_c) it_q <= it_q + 8'd1;
          end
        end
        kce_pkg::OP_UP_ACC: begin
          if (!last_p) begin
            p_q     <= p_q + PW'(1);
            paddr_q <= paddr_q + d_addr;
          end
        end
        kce_pkg::OP_UP_WR: begin
          p_q <= '0;
          if (!last_j) begin
            j_q     <= j_q + DW'(1);
            paddr_q <= AW'(j_q + DW'(1));
          end else begin
            j_q     <= '0;
            paddr_q <= '0;
            c_q     <= c_q + KW'(1);
            if (last_c) it_q <= it_q + 8'd1;
          end
        end
        kce_pkg::OP_EMIT_START: p_q <= '0;
        kce_pkg::OP_EMIT_NEXT:  p_q <= p_q + PW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      kce_pkg::OP_ITER: dist_q <= '0;
      kce_pkg::OP_AS_SQ: sq_q <= SQW'(prod);
      kce_pkg::OP_AS_ACC: begin
        if (!last_j) begin
          dist_q <= dist_d;
        end else begin
          dist_q <= '0;
          if ((c_q == '0) || (dist_d < best_q)) best_q <= dist_d;
        end
      end
      kce_pkg::OP_UP_CHK: sum_q <= '0;
      kce_pkg::OP_UP_ACC: begin
        if (ldata_q == c_q[LW-1:0]) sum_q <= sum_q + pdata_ext;
      end
      kce_pkg::OP_UP_WR: sum_q <= '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((op_i == kce_pkg::OP_LOAD) && (cnt_q < CW'(DEPTH))) begin
      pmem[cnt_q[AW-1:0]] <= coordinate_i;
    end
    if ((op_i == kce_pkg::OP_INIT_RD) || (op_i == kce_pkg::OP_AS_RD) ||
        (op_i == kce_pkg::OP_UP_RD)) begin
      pdata_q <= pmem[paddr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == kce_pkg::OP_INIT_WR) begin
      cmem[caddr] <= pdata_q;
    end else if (op_i == kce_pkg::OP_UP_WR) begin
      cmem[caddr] <= quot[COORD_WIDTH-1:0];
    end
    if (op_i == kce_pkg::OP_AS_RD) begin
      cdata_q <= cmem[caddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == kce_pkg::OP_AS_WR) begin
      lmem[p_q[PIW-1:0]] <= bestc_q;
    end
    if ((op_i == kce_pkg::OP_UP_RD) || (op_i == kce_pkg::OP_EMIT_RD)) begin
      ldata_q <= lmem[p_q[PIW-1:0]];
    end
  end

  kce_div #(
    .DVW(SW),
    .DSW(PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op_i == kce_pkg::OP_DIV_START),
    .dividend_i (sum_q),
    .divisor_i  (counts_q[c_q[LW-1:0]]),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign pi_ext          = {6'd0, p_q};
  assign lb_ext          = {4'd0, ldata_q};
  assign assigned_o      = iters_q != 8'd0;
  assign point_index_o   = pi_ext[5:0];
  assign cluster_label_o = assigned_o ? lb_ext[3:0] : 4'd0;
  assign last_o          = last_p;

endmodule
`default_nettype wire

@@ rtl/kce_ctrl.sv @@
`default_nettype none
`include "kmeans_cluster_engine_core_assert.svh"
module kce_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          last_of_set_i,
  input  wire logic          out_ready_i,
  input  wire kce_pkg::sts_t sts_i,
  output kce_pkg::op_e       op_o,
  output logic               in_ready_o,
  output logic               out_valid_o
);

  kce_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      kce_pkg::S_LOAD: begin
        if (in_valid_i && last_of_set_i) state_d = kce_pkg::S_COUNT;
      end
      kce_pkg::S_COUNT: begin
        if (sts_i.count_done) begin
          state_d = sts_i.n_zero ? kce_pkg::S_LOAD : kce_pkg::S_INIT_RD;
        end
      end
      kce_pkg::S_INIT_RD: state_d = kce_pkg::S_INIT_WR;
      kce_pkg::S_INIT_WR: begin
        state_d = (sts_i.last_j && sts_i.last_c) ? kce_pkg::S_ITER : kce_pkg::S_INIT_RD;
      end
      kce_pkg::S_ITER: begin
        state_d = sts_i.iter_done ? kce_pkg::S_EMIT_RD : kce_pkg::S_AS_RD;
      end
      kce_pkg::S_AS_RD: state_d = kce_pkg::S_AS_SQ;
      kce_pkg::S_AS_SQ: state_d = kce_pkg::S_AS_ACC;
      kce_pkg::S_AS_ACC: begin
        state_d = (sts_i.last_j && sts_i.last_c) ? kce_pkg::S_AS_WR : kce_pkg::S_AS_RD;
      end
      kce_pkg::S_AS_WR: begin
        state_d = sts_i.last_p ? kce_pkg::S_UP_CHK : kce_pkg::S_AS_RD;
      end
      kce_pkg::S_UP_CHK: begin
        if (!sts_i.cnt_zero) begin
          state_d = kce_pkg::S_UP_RD;
        end else if (sts_i.last_c) begin
          state_d = kce_pkg::S_ITER;
        end
      end
      kce_pkg::S_UP_RD: state_d = kce_pkg::S_UP_ACC;
      kce_pkg::S_UP_ACC: begin
        state_d = sts_i.last_p ? kce_pkg::S_UP_DIV : kce_pkg::S_UP_RD;
      end
      kce_pkg::S_UP_DIV: state_d = kce_pkg::S_UP_WAIT;
      kce_pkg::S_UP_WAIT: begin
        if (sts_i.div_done) state_d = kce_pkg::S_UP_WR;
      end
      kce_pkg::S_UP_WR: begin
        if (!sts_i.last_j) begin
          state_d = kce_pkg::S_UP_RD;
        end else begin
          state_d = sts_i.last_c ? kce_pkg::S_ITER : kce_pkg::S_UP_CHK;
        end
      end
      kce_pkg::S_EMIT_RD: state_d = kce_pkg::S_EMIT;
      kce_pkg::S_EMIT: begin
        if (out_ready_i) state_d = sts_i.last_p ? kce_pkg::S_LOAD : kce_pkg::S_EMIT_RD;
      end
      default: state_d = kce_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    op_o        = kce_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      kce_pkg::S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = kce_pkg::OP_LOAD;
      end
      kce_pkg::S_COUNT: begin
        if (!sts_i.count_done) begin
          op_o = kce_pkg::OP_COUNT;
        end else if (!sts_i.n_zero) begin
          op_o = kce_pkg::OP_INIT_START;
        end
      end
      kce_pkg::S_INIT_RD: op_o = kce_pkg::OP_INIT_RD;
      kce_pkg::S_INIT_WR: op_o = kce_pkg::OP_INIT_WR;
      kce_pkg::S_ITER: begin
        op_o = sts_i.iter_done ? kce_pkg::OP_EMIT_START : kce_pkg::OP_ITER;
      end
      kce_pkg::S_AS_RD:   op_o = kce_pkg::OP_AS_RD;
      kce_pkg::S_AS_SQ:   op_o = kce_pkg::OP_AS_SQ;
      kce_pkg::S_AS_ACC:  op_o = kce_pkg::OP_AS_ACC;
      kce_pkg::S_AS_WR:   op_o = kce_pkg::OP_AS_WR;
      kce_pkg::S_UP_CHK:  op_o = kce_pkg::OP_UP_CHK;
      kce_pkg::S_UP_RD:   op_o = kce_pkg::OP_UP_RD;
      kce_pkg::S_UP_ACC:  op_o = kce_pkg::OP_UP_ACC;
      kce_pkg::S_UP_DIV:  op_o = kce_pkg::OP_DIV_START;
      kce_pkg::S_UP_WAIT: op_o = kce_pkg::OP_NONE;
      kce_pkg::S_UP_WR:   op_o = kce_pkg::OP_UP_WR;
      kce_pkg::S_EMIT_RD: op_o = kce_pkg::OP_EMIT_RD;
      kce_pkg::S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) op_o = kce_pkg::OP_EMIT_NEXT;
      end
      default: op_o = kce_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kce_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  `KCE_ASSERT_IMP(a_no_load_while_emit, out_valid_o, !in_ready_o)
  `KCE_ASSERT_NXT(a_final_label_frees, out_valid_o && out_ready_i && sts_i.last_p, in_ready_o)
  `KCE_ASSERT_NXT(a_empty_set_reloads, (state_q == kce_pkg::S_COUNT) && sts_i.count_done && sts_i.n_zero, in_ready_o)

endmodule
`default_nettype wire

@@ rtl/kmeans_cluster_engine_core.sv @@
// k-means clustering engine (lloyd iterations, first k points as seeds)
// input channel: one signed coordinate per transaction, point after point;
//   last_of_set_i marks the final coordinate of the data set. loading takes
//   one coordinate per cycle into the point memory.
// after the set closes the block stops accepting input and works alone:
//   it counts the points, seeds the centroids, then per iteration runs the
//   assignment and the update; the update uses a serial divider with a sum
//   width of 24 bits by default, and the datapath has a single squarer and
//   one-port memories.
// output channel: one label transaction per point in load order, with last_o
//   on the final point; each label is read from the label memory before it
//   is offered. a stalled receiver holds the current label and the block
//   waits; the next set is taken once the final label has been accepted.
// configuration writes are taken at any time and apply when a set closes.
// reset clears the control state, counters and configuration to defaults; the
//   payload registers and point, centroid and label memories are not cleared.
`default_nettype none
module kmeans_cluster_engine_core #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 32,
  parameter int COORD_WIDTH  = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [7:0]             cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [COORD_WIDTH-1:0] coordinate_i,
  input  wire logic                   last_of_set_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [5:0]                  point_index_o,
  output logic [3:0]                  cluster_label_o,
  output logic                        assigned_o,
  output logic                        last_o
);

  kce_pkg::op_e  op;
  kce_pkg::sts_t sts;

  kce_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_of_set_i (last_of_set_i),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .op_o          (op),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o)
  );

  kce_datapath #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_DIMS     (MAX_DIMS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op),
    .coordinate_i    (coordinate_i),
    .last_of_set_i   (last_of_set_i),
    .sts_o           (sts),
    .point_index_o   (point_index_o),
    .cluster_label_o (cluster_label_o),
    .assigned_o      (assigned_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire
